@@ hdl/pst_pkg.sv @@
package pst_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int KIND_W   = 3;
    localparam int COORD_W  = 16;
    localparam int RADIUS_W = 24;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;

    // operation codes carried in the kind field
    localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_COUNT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

    typedef struct packed {
        logic valid;
        logic hit;
    } dist_rsp_t;

endpackage

@@ hdl/pst_mem.sv @@
module pst_mem
    import pst_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  point_t                              wr_data,
    input  logic                                rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic                                rd_valid,
    output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_q,
    output point_t                              rd_data
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    point_t              mem [DEPTH];
    logic                rd_valid_reg;
    logic [ADDR_W-1:0]   rd_addr_reg;
    point_t              rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // tag each read return so the sequencer can match it to its address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_en;
        end
    end

    assign rd_valid  = rd_valid_reg;
    assign rd_addr_q = rd_addr_reg;
    assign rd_data   = rd_data_reg;

endmodule

@@ hdl/pst_dist.sv @@
module pst_dist
    import pst_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  point_t              pt,
    input  logic [RADIUS_W-1:0] radius,
    output dist_rsp_t           rsp
);

    localparam int SQ_W  = 2 * COORD_W;
    localparam int LIM_W = 2 * RADIUS_W;
    localparam int D_W   = SQ_W + 1 + 16;

    logic [COORD_W-1:0] mag_x;
    logic [COORD_W-1:0] mag_y;
    logic [LIM_W-1:0]   lim_reg;
    logic [SQ_W-1:0]    sq_x_reg;
    logic [SQ_W-1:0]    sq_y_reg;
    logic               sq_valid_reg;
    dist_rsp_t          rsp_reg;
    logic [SQ_W:0]      sum;
    logic [D_W-1:0]     dist_sq;

    // magnitude of a 16-bit signed value fits 16 unsigned bits, -32768 included
    assign mag_x = pt.x[COORD_W-1] ? COORD_W'(-pt.x) : COORD_W'(pt.x);
    assign mag_y = pt.y[COORD_W-1] ? COORD_W'(-pt.y) : COORD_W'(pt.y);

    assign sum     = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
    assign dist_sq = {sum, 16'h0000};

    always_ff @(posedge clk)
    begin
        lim_reg  <= LIM_W'(radius) * LIM_W'(radius);
        sq_x_reg <= SQ_W'(mag_x) * SQ_W'(mag_x);
        sq_y_reg <= SQ_W'(mag_y) * SQ_W'(mag_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
            rsp_reg      <= '0;
        end
        else
        begin
            sq_valid_reg  <= in_valid;
            rsp_reg.valid <= sq_valid_reg;
            rsp_reg.hit   <= (dist_sq <= D_W'(lim_reg));
        end
    end

    assign rsp = rsp_reg;

endmodule

@@ hdl/point_stack_table_with_radius_count_unit.sv @@
// Push, pop and unused kinds pass through the exec and result states to a registered output.
// Search and remove scan newest first, one entry per cycle; remove then moves each point
// newer than the match one slot down, to close the gap.
// Radius count reads every stored entry through the distance pipeline. One item in flight at a time.
// Reset (rst_n, async, low) empties the table; point memory contents stay undefined.
module point_stack_table_with_radius_count_unit
    import pst_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [KIND_W-1:0]          kind,
    input  logic signed [COORD_W-1:0]  px,
    input  logic signed [COORD_W-1:0]  py,
    input  logic [RADIUS_W-1:0]        radius,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [STATUS_W-1:0]        status,
    output logic                       found,
    output logic [LEN_W-1:0]           within_count,
    output logic [LEN_W-1:0]           length
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W  = $clog2(DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_SHIFT  = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [OCC_W-1:0]      occ_reg, occ_next;
    logic [ADDR_W-1:0]     issue_addr_reg, issue_addr_next;
    logic                  issue_on_reg, issue_on_next;
    logic [ADDR_W-1:0]     key_addr_reg, key_addr_next;
    logic [OCC_W-1:0]      cnt_reg, cnt_next;
    logic [OCC_W-1:0]      within_reg, within_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                  res_found_reg, res_found_next;

    // item payload, held for the whole operation
    logic [KIND_W-1:0]     kind_reg;
    point_t                item_pt_reg;
    logic [RADIUS_W-1:0]   radius_reg;

    // output slot
    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   status_reg;
    logic                  found_reg;
    logic [LEN_W-1:0]      within_count_reg;
    logic [LEN_W-1:0]      length_reg;

    logic                  in_accept;
    logic                  out_load;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    point_t                wr_data;
    logic                  rd_valid;
    logic [ADDR_W-1:0]     rd_addr_q;
    point_t                rd_data;
    dist_rsp_t             dist_rsp;
    logic [ADDR_W-1:0]     last_addr;
    logic [OCC_W-1:0]      last_cnt;

    // Point memory: one write port, one read port with a registered, address-tagged return.
    // Accesses never touch the same entry in one cycle: a push writes while nothing reads,
    // and the compaction writes an entry two below the one being read.
    pst_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (issue_on_reg),
        .rd_addr   (issue_addr_reg),
        .rd_valid  (rd_valid),
        .rd_addr_q (rd_addr_q),
        .rd_data   (rd_data)
    );

    // Distance test pipeline: squares, then sum and compare against radius squared.
    pst_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rd_valid),
        .pt       (rd_data),
        .radius   (radius_reg),
        .rsp      (dist_rsp)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;

    // slot of the newest point, and the count that marks the last scanned entry
    assign last_addr = ADDR_W'(occ_reg - 1'b1);
    assign last_cnt  = occ_reg - 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        occ_next        = occ_reg;
        issue_addr_next = issue_addr_reg;
        issue_on_next   = issue_on_reg;
        key_addr_next   = key_addr_reg;
        cnt_next        = cnt_reg;
        within_next     = within_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        wr_en           = 1'b0;
        wr_addr         = ADDR_W'(occ_reg);
        wr_data         = item_pt_reg;
        out_load        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_status_next = ST_OK;
                res_found_next  = 1'b0;
                within_next     = '0;
                cnt_next        = '0;
                state_next      = S_RESULT;
                unique case (kind_reg)
                    KIND_PUSH:
                    begin
                        // drop the point when the table is full
                        if (occ_reg == OCC_W'(DEPTH))
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_en    = 1'b1;
                            occ_next = occ_reg + 1'b1;
                        end
                    end
                    KIND_POP:
                    begin
                        if (occ_reg == '0)
                        begin
                            res_status_next = ST_MISS;
                        end
                        else
                        begin
                            occ_next = occ_reg - 1'b1;
                        end
                    end
                    KIND_REMOVE, KIND_SEARCH:
                    begin
                        if (occ_reg == '0)
                        begin
                            // only remove reports a miss; search just leaves found low
                            if (kind_reg == KIND_REMOVE)
                            begin
                                res_status_next = ST_MISS;
                            end
                        end
                        else
                        begin
                            // scan from the newest slot down
                            issue_addr_next = last_addr;
                            issue_on_next   = 1'b1;
                            state_next      = S_SCAN;
                        end
                    end
                    KIND_COUNT:
                    begin
                        if (occ_reg != '0)
                        begin
                            issue_addr_next = last_addr;
                            issue_on_next   = 1'b1;
                            state_next      = S_SCAN;
                        end
                    end
                    default:
                    begin
                        // unused kinds change nothing
                    end
                endcase
            end

            S_SCAN:
            begin
                // advance the read pointer toward slot zero
                if (issue_on_reg)
                begin
                    if (issue_addr_reg == '0)
                    begin
                        issue_on_next = 1'b0;
                    end
                    else
                    begin
                        issue_addr_next = issue_addr_reg - 1'b1;
                    end
                end

                if (kind_reg == KIND_COUNT)
                begin
                    // every stored entry comes back through the distance pipeline once
                    if (dist_rsp.valid)
                    begin
                        cnt_next    = cnt_reg + 1'b1;
                        within_next = within_reg + OCC_W'(dist_rsp.hit);
                        if (cnt_reg == last_cnt)
                        begin
                            state_next = S_RESULT;
                        end
                    end
                end
                else if (rd_valid)
                begin
                    if (rd_data == item_pt_reg)
                    begin
                        // newest match found: stop the scan, drop the read still in flight
                        issue_on_next = 1'b0;
                        if (kind_reg == KIND_SEARCH)
                        begin
                            res_found_next = 1'b1;
                            state_next     = S_RESULT;
                        end
                        else if (rd_addr_q == last_addr)
                        begin
                            // match is the newest point: no gap to close
                            occ_next   = occ_reg - 1'b1;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            key_addr_next   = rd_addr_q;
                            issue_addr_next = rd_addr_q + 1'b1;
                            issue_on_next   = 1'b1;
                            state_next      = S_SHIFT;
                        end
                    end
                    else if (rd_addr_q == '0)
                    begin
                        // whole table read without a match
                        if (kind_reg == KIND_REMOVE)
                        begin
                            res_status_next = ST_MISS;
                        end
                        state_next = S_RESULT;
                    end
                end
            end

            S_SHIFT:
            begin
                // read the newer points upward, one per cycle
                if (issue_on_reg)
                begin
                    if (issue_addr_reg == last_addr)
                    begin
                        issue_on_next = 1'b0;
                    end
                    else
                    begin
                        issue_addr_next = issue_addr_reg + 1'b1;
                    end
                end

                // write each one a slot lower; the stale scan return lies below the key
                if (rd_valid && (rd_addr_q > key_addr_reg))
                begin
                    wr_en   = 1'b1;
                    wr_addr = rd_addr_q - 1'b1;
                    wr_data = rd_data;
                    if (rd_addr_q == last_addr)
                    begin
                        occ_next   = occ_reg - 1'b1;
                        state_next = S_RESULT;
                    end
                end
            end

            S_RESULT:
            begin
                // hold until the output slot is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            occ_reg        <= '0;
            issue_addr_reg <= '0;
            issue_on_reg   <= 1'b0;
            key_addr_reg   <= '0;
            cnt_reg        <= '0;
            within_reg     <= '0;
            res_status_reg <= ST_OK;
            res_found_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            occ_reg        <= occ_next;
            issue_addr_reg <= issue_addr_next;
            issue_on_reg   <= issue_on_next;
            key_addr_reg   <= key_addr_next;
            cnt_reg        <= cnt_next;
            within_reg     <= within_next;
            res_status_reg <= res_status_next;
            res_found_reg  <= res_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers: item on accept, result on load
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            kind_reg      <= kind;
            item_pt_reg.x <= px;
            item_pt_reg.y <= py;
            radius_reg    <= radius;
        end
        if (out_load)
        begin
            status_reg       <= res_status_reg;
            found_reg        <= res_found_reg;
            within_count_reg <= LEN_W'(within_reg);
            length_reg       <= LEN_W'(occ_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign found        = found_reg;
    assign within_count = within_count_reg;
    assign length       = length_reg;

    // table never grows past its depth
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(DEPTH))
        else $error("occupancy beyond depth");

    // reads stay inside the stored part of the table
    a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        issue_on_reg |-> (OCC_W'(issue_addr_reg) < occ_reg))
        else $error("read beyond occupancy");

    // writes land at most one slot past the newest point
    a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ((OCC_W'(wr_addr) <= occ_reg) && (state_reg != S_IDLE)))
        else $error("write outside the table");

    // a loaded result reports the occupancy left by its operation
    a_len_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (length == LEN_W'(occ_reg)))
        else $error("length does not match occupancy");

endmodule

@@ test/point_stack_table_with_radius_count_unit_tb.sv @@
`timescale 1ns / 100ps

module point_stack_table_with_radius_count_unit_tb;
    import pst_pkg::*;

    localparam int TBL_DEPTH      = DEPTH_DEF;
    localparam int RANDOM_ITEMS   = 600;
    localparam int CYCLE_LIMIT    = 400000;
    // Longest scan is a remove at full depth.
    localparam int SETTLE_CYCLES  = 2 * TBL_DEPTH + 20;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int HOLDOFF_AFTER  = 100;
    localparam int MAX_REPORTS    = 10;

    // Selector values the block leaves unused; they must change nothing.
    localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;

    localparam logic signed [COORD_W-1:0] COORD_MIN  = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] COORD_MAX  = ~COORD_MIN;
    localparam logic [RADIUS_W-1:0]       RADIUS_MAX = '1;

    typedef enum int { LOAD_MIXED, LOAD_FILL, LOAD_DRAIN } load_mode_t;

    typedef struct {
        logic [KIND_W-1:0]         kind;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [RADIUS_W-1:0]       radius;
    } table_op_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [LEN_W-1:0]    near_cnt;
        logic [LEN_W-1:0]    length;
    } table_reply_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    logic [KIND_W-1:0]          kind      = '0;
    logic signed [COORD_W-1:0]  px        = '0;
    logic signed [COORD_W-1:0]  py        = '0;
    logic [RADIUS_W-1:0]        radius    = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [STATUS_W-1:0]        status;
    logic                       found;
    logic [LEN_W-1:0]           within_count;
    logic [LEN_W-1:0]           length;

    point_stack_table_with_radius_count_unit #(
        .DEPTH(TBL_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .px(px),
        .py(py),
        .radius(radius),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .found(found),
        .within_count(within_count),
        .length(length)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hold reset at the start, then release it for good.
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Point table predictor: its own copy of the stored points, oldest in
    // slot 0, newest in slot shadow_len-1.
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] shadow_x [TBL_DEPTH];
    logic signed [COORD_W-1:0] shadow_y [TBL_DEPTH];
    int                        shadow_len = 0;

    // Return the slot of the newest stored copy of (x,y), or -1.
    function automatic int newest_match(logic signed [COORD_W-1:0] x,
                                        logic signed [COORD_W-1:0] y);
        int i;
        for (i = shadow_len - 1; i >= 0; i--)
            if (shadow_x[i] == x && shadow_y[i] == y)
                return i;
        return -1;
    endfunction

    // Apply one item to the table and return the result it must produce.
    function automatic table_reply_t apply_op(table_op_t op);
        table_reply_t rep;
        int           slot;
        int           i;
        int           hits;
        longint       sx;
        longint       sy;
        logic [63:0]  limit_sq;
        rep.status   = ST_OK;
        rep.found    = 1'b0;
        rep.near_cnt = '0;
        hits         = 0;
        case (op.kind)
            KIND_PUSH:
                if (shadow_len >= TBL_DEPTH)
                    rep.status = ST_FULL;
                else
                begin
                    shadow_x[shadow_len] = op.x;
                    shadow_y[shadow_len] = op.y;
                    shadow_len++;
                end
            KIND_POP:
                if (shadow_len == 0)
                    rep.status = ST_MISS;
                else
                    shadow_len--;
            KIND_REMOVE:
            begin
                slot = newest_match(op.x, op.y);
                if (slot < 0)
                    rep.status = ST_MISS;
                else
                begin
                    // Close the gap: newer points slide down one slot, order kept.
                    for (i = slot; i < shadow_len - 1; i++)
                    begin
                        shadow_x[i] = shadow_x[i + 1];
                        shadow_y[i] = shadow_y[i + 1];
                    end
                    shadow_len--;
                end
            end
            KIND_COUNT:
            begin
                // Exact form of sqrt(x^2+y^2) <= radius/256: scale the squared
                // distance by 2^16 instead of taking a root.
                limit_sq = 64'(op.radius) * 64'(op.radius);
                for (i = 0; i < shadow_len; i++)
                begin
                    sx = shadow_x[i];
                    sy = shadow_y[i];
                    if ((64'(sx * sx + sy * sy) << 16) <= limit_sq)
                        hits++;
                end
                rep.near_cnt = LEN_W'(hits);
            end
            KIND_SEARCH:
                rep.found = (newest_match(op.x, op.y) >= 0);
            default:
                ;
        endcase
        rep.length = LEN_W'(shadow_len);
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation. live_pts tracks what the table should hold at
    // each point of the sequence so removes and searches can aim at
    // stored points.
    // ------------------------------------------------------------------
    table_op_t    pending_ops[$];
    table_reply_t awaited_replies[$];
    point_t       live_pts[$];
    int           pause_marks[$];

    task automatic queue_op(logic [KIND_W-1:0] k, logic signed [COORD_W-1:0] x,
                            logic signed [COORD_W-1:0] y, logic [RADIUS_W-1:0] r);
        table_op_t op;
        point_t    p;
        int        i;
        op.kind   = k;
        op.x      = x;
        op.y      = y;
        op.radius = r;
        pending_ops.push_back(op);
        p.x = x;
        p.y = y;
        case (k)
            KIND_PUSH:
                if (live_pts.size() < TBL_DEPTH)
                    live_pts.push_back(p);
            KIND_POP:
                if (live_pts.size() > 0)
                    void'(live_pts.pop_back());
            KIND_REMOVE:
                for (i = live_pts.size() - 1; i >= 0; i--)
                    if (live_pts[i] == p)
                    begin
                        live_pts.delete(i);
                        break;
                    end
            default:
                ;
        endcase
    endtask

    // Small values make duplicates likely; extremes and full-range values
    // toggle every coordinate bit.
    function automatic logic signed [COORD_W-1:0] pick_coord();
        int                        s;
        logic signed [COORD_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
                v = COORD_W'(int'($urandom_range(0, 6)) - 3);
            4:
                case ($urandom_range(0, 3))
                    0:       v = COORD_MIN;
                    1:       v = COORD_MAX;
                    2:       v = '0;
                    default: v = '1;
                endcase
            5, 6:
                v = COORD_W'($urandom);
            default:
            begin
                s = $urandom_range(1, COORD_W - 1);
                v = COORD_W'($urandom & ((32'd1 << s) - 1));
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic point_t pick_point(int reuse_pct);
        point_t p;
        if (live_pts.size() > 0 && $urandom_range(0, 99) < reuse_pct)
            return live_pts[$urandom_range(0, live_pts.size() - 1)];
        p.x = pick_coord();
        p.y = pick_coord();
        return p;
    endfunction

    // Radii often sit right at the distance of a stored point, one LSB
    // either side, to hit the boundary of the compare.
    function automatic logic [RADIUS_W-1:0] pick_radius();
        point_t p;
        real    span;
        longint r;
        int     s;
        case ($urandom_range(0, 9))
            0:
                return '0;
            1:
                return RADIUS_MAX;
            2, 3, 4, 5:
            begin
                if (live_pts.size() == 0)
                    return RADIUS_W'($urandom);
                p    = live_pts[$urandom_range(0, live_pts.size() - 1)];
                span = $sqrt(real'(p.x) * real'(p.x) + real'(p.y) * real'(p.y)) * 256.0;
                r    = longint'(span) + longint'($urandom_range(0, 2)) - 1;
                if (r < 0)
                    r = 0;
                return RADIUS_W'(r);
            end
            default:
            begin
                s = $urandom_range(1, RADIUS_W);
                return RADIUS_W'($urandom & ((32'd1 << s) - 1));
            end
        endcase
    endfunction

    // Fill mode leans on pushes, drain mode on pops and removes, mixed
    // mode spreads evenly and sprinkles in the unused selectors.
    task automatic add_random(load_mode_t mode);
        logic [KIND_W-1:0] k;
        point_t            p;
        int                roll;
        roll = $urandom_range(0, 99);
        case (mode)
            LOAD_FILL:
                k = (roll < 80) ? KIND_PUSH :
                    (roll < 88) ? KIND_SEARCH :
                    (roll < 94) ? KIND_COUNT : KIND_REMOVE;
            LOAD_DRAIN:
                k = (roll < 45) ? KIND_POP :
                    (roll < 85) ? KIND_REMOVE :
                    (roll < 93) ? KIND_COUNT : KIND_SEARCH;
            default:
                k = (roll < 25) ? KIND_PUSH :
                    (roll < 40) ? KIND_POP :
                    (roll < 55) ? KIND_REMOVE :
                    (roll < 75) ? KIND_COUNT :
                    (roll < 96) ? KIND_SEARCH :
                    KIND_SPARE_FIRST + KIND_W'($urandom_range(0, 2));
        endcase
        p = pick_point((k == KIND_PUSH) ? 15 : 70);
        queue_op(k, p.x, p.y, pick_radius());
    endtask

    // ------------------------------------------------------------------
    // Driver: offer items in bursts with random gaps; hold the payload
    // while stalled; predict each item at the edge where it is taken.
    // ------------------------------------------------------------------
    int items_sent  = 0;
    int burst_left  = 0;
    int gap_left    = 0;
    int kind_tally[8];
    int full_drops  = 0;
    int miss_count  = 0;
    int search_hits = 0;
    int peak_len    = 0;

    always @(posedge clk)
    begin : drive_items
        table_op_t    head;
        table_reply_t rep;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                head = pending_ops.pop_front();
                rep  = apply_op(head);
                awaited_replies.push_back(rep);
                items_sent++;
                kind_tally[head.kind]++;
                if (rep.status == ST_FULL)
                    full_drops++;
                if (rep.status == ST_MISS)
                    miss_count++;
                if (rep.found)
                    search_hits++;
                if (int'(rep.length) > peak_len)
                    peak_len = rep.length;
            end

            // A stalled item stays on the bus untouched.
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_ops.size() == 0 ||
                         (pause_marks.size() > 0 && items_sent == pause_marks[0] &&
                          awaited_replies.size() > 0))
                    // Out of items, or pausing until every result is back.
                    in_valid <= 1'b0;
                else
                begin
                    if (pause_marks.size() > 0 && items_sent == pause_marks[0])
                        void'(pause_marks.pop_front());
                    in_valid <= 1'b1;
                    kind     <= pending_ops[0].kind;
                    px       <= pending_ops[0].x;
                    py       <= pending_ops[0].y;
                    radius   <= pending_ops[0].radius;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        // End of burst: pick the next burst and the gap before it;
                        // a quarter of the time run straight on.
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall: random duty phases, plus one long hold-off so the
    // block backs up and stalls its input while items keep coming.
    // ------------------------------------------------------------------
    int replies_checked = 0;
    int stall_pct       = 0;
    int phase_left      = 0;
    int holdoff_left    = 0;
    bit holdoff_done    = 1'b0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                out_stall <= 1'b1;
            end
            else if (!holdoff_done && replies_checked >= HOLDOFF_AFTER)
            begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_CYCLES;
                out_stall   <= 1'b1;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    phase_left = $urandom_range(20, 200);
                    case ($urandom_range(0, 3))
                        0:       stall_pct = 0;
                        1:       stall_pct = 20;
                        2:       stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end
                else
                    phase_left--;
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare every taken result with the oldest prediction.
    // ------------------------------------------------------------------
    int mismatches = 0;

    task automatic log_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch: %s", $time, what);
    endtask

    always @(posedge clk)
    begin : check_replies
        table_reply_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_replies.size() == 0)
                log_mismatch($sformatf("result with none pending: status=%0d found=%0d within=%0d length=%0d",
                                       status, found, within_count, length));
            else
            begin
                want = awaited_replies.pop_front();
                replies_checked++;
                if (status !== want.status || found !== want.found ||
                    within_count !== want.near_cnt || length !== want.length)
                    log_mismatch($sformatf(
                        "result %0d: expected status=%0d found=%0d within=%0d length=%0d, got status=%0d found=%0d within=%0d length=%0d",
                        replies_checked, want.status, want.found, want.near_cnt, want.length,
                        status, found, within_count, length));
            end
        end
    end

    // Watchdog: stop a hung run.
    int cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout at cycle %0d: %0d items unsent, %0d results outstanding",
                     cycle_count, pending_ops.size(), awaited_replies.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: directed corners, then random load phases; then drain and
    // report.
    // ------------------------------------------------------------------
    initial
    begin : run_sequence
        int directed_count;
        int extra;

        // Empty table: pop, search, remove and count must all see nothing.
        queue_op(KIND_POP,    '0, '0, '0);
        queue_op(KIND_SEARCH, '0, '0, '0);
        queue_op(KIND_REMOVE, '0, '0, '0);
        queue_op(KIND_COUNT,  '0, '0, RADIUS_MAX);
        // Unused selectors leave the table alone.
        queue_op(KIND_SPARE_FIRST,         COORD_MAX, COORD_MIN, RADIUS_MAX);
        queue_op(KIND_SPARE_FIRST + 3'd1,  COORD_MIN, COORD_MAX, '0);
        queue_op(KIND_SPARE_FIRST + 3'd2,  '1,        '1,        RADIUS_MAX);
        // Extremes, the origin, and (3,4) twice with a point between and after.
        queue_op(KIND_PUSH, COORD_MIN, COORD_MIN, '0);
        queue_op(KIND_PUSH, COORD_MAX, COORD_MAX, '0);
        queue_op(KIND_PUSH, 16'sd0,  16'sd0,  '0);
        queue_op(KIND_PUSH, 16'sd3,  16'sd4,  '0);
        queue_op(KIND_PUSH, -16'sd1, -16'sd1, '0);
        queue_op(KIND_PUSH, 16'sd3,  16'sd4,  '0);
        queue_op(KIND_PUSH, 16'sd5,  -16'sd7, '0);
        // Zero radius takes the origin only; 5.0 exactly takes (3,4) on the
        // boundary, one LSB less does not; full radius takes everything.
        queue_op(KIND_COUNT, '0, '0, 24'd0);
        queue_op(KIND_COUNT, '0, '0, 24'd1280);
        queue_op(KIND_COUNT, '0, '0, 24'd1279);
        queue_op(KIND_COUNT, '0, '0, RADIUS_MAX);
        queue_op(KIND_SEARCH, 16'sd3, 16'sd4, '0);
        // Duplicates: the newest copy goes first, then the older one.
        queue_op(KIND_REMOVE, 16'sd3, 16'sd4, '0);
        queue_op(KIND_REMOVE, 16'sd3, 16'sd4, '0);
        queue_op(KIND_REMOVE, 16'sd7, 16'sd7, '0);
        queue_op(KIND_SEARCH, 16'sd3, 16'sd4, '0);
        queue_op(KIND_POP,    '0, '0, '0);
        queue_op(KIND_SEARCH, COORD_MIN, COORD_MIN, '0);
        directed_count = pending_ops.size();

        // Let the directed part finish before random load starts, and
        // pause once more in the middle of it.
        pause_marks.push_back(directed_count);
        pause_marks.push_back(directed_count + RANDOM_ITEMS / 2);

        while (pending_ops.size() < directed_count + RANDOM_ITEMS)
        begin
            repeat (80) add_random(LOAD_MIXED);
            // Fill to the top and keep pushing past full a few times.
            extra = 0;
            while (extra < 6)
            begin
                if (live_pts.size() == TBL_DEPTH)
                    extra++;
                add_random(LOAD_FILL);
            end
            repeat (60) add_random(LOAD_MIXED);
            // Empty out and keep popping and removing on an empty table.
            extra = 0;
            while (extra < 4)
            begin
                if (live_pts.size() == 0)
                    extra++;
                add_random(LOAD_DRAIN);
            end
        end

        // Wait until every item is taken and every result is back, then
        // give any stray result time to show up.
        while (pending_ops.size() != 0 || awaited_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d items: %0d push, %0d pop, %0d remove, %0d count, %0d search, %0d unused kind",
                 items_sent, kind_tally[KIND_PUSH], kind_tally[KIND_POP],
                 kind_tally[KIND_REMOVE], kind_tally[KIND_COUNT], kind_tally[KIND_SEARCH],
                 items_sent - kind_tally[KIND_PUSH] - kind_tally[KIND_POP] -
                 kind_tally[KIND_REMOVE] - kind_tally[KIND_COUNT] - kind_tally[KIND_SEARCH]);
        $display("%0d results checked, peak length %0d, %0d pushes dropped full, %0d misses, %0d search hits, %0d mismatches",
                 replies_checked, peak_len, full_drops, miss_count, search_hits, mismatches);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
